// ===== design/mte_pkg.sv =====
// shared types, constants and helper functions for the midi track event encoder
`timescale 1ns / 1ps
`default_nettype none

package mte_pkg;

   localparam int MTE_QUEUE_DEPTH = 2;
   localparam int MTE_MSG_BYTES   = 7;

   typedef enum logic [3:0] {
      OP_NOTE_OFF   = 4'd0,
      OP_NOTE_ON    = 4'd1,
      OP_POLY_PRESS = 4'd2,
      OP_CTRL       = 4'd3,
      OP_PROGRAM    = 4'd4,
      OP_CHAN_PRESS = 4'd5,
      OP_BEND       = 4'd6,
      OP_TEMPO      = 4'd7,
      OP_TIMESIG    = 4'd8,
      OP_NAME       = 4'd9,
      OP_EOT        = 4'd10,
      OP_TEXT       = 4'd11,
      OP_SYSEX      = 4'd12,
      OP_UNK_META   = 4'd13,
      OP_PAYLOAD    = 4'd14,
      OP_CLOSE      = 4'd15
   } mte_opcode_type;

   localparam logic [7:0] META_PREFIX  = 8'hFF;
   localparam logic [7:0] META_NAME    = 8'h03;
   localparam logic [7:0] META_TEMPO   = 8'h51;
   localparam logic [7:0] META_TIMESIG = 8'h58;
   localparam logic [7:0] META_EOT     = 8'h2F;
   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] LEN_ZERO     = 8'h00;
   localparam logic [7:0] LEN_TEMPO    = 8'h03;
   localparam logic [7:0] LEN_TIMESIG  = 8'h04;
   localparam logic [3:0] STATUS_BEND  = 4'hE;

   typedef struct packed {
      logic                              has_delta;
      logic [31:0]                       delta;
      logic [MTE_MSG_BYTES-1:0][7:0]     msg;
      logic [2:0]                        msg_len;
      logic                              has_plen;
      logic [31:0]                       plen;
   } mte_cmd_type;

   // index of the most significant 7-bit group of a quantity
   function automatic logic [2:0] vlq_top(input logic [31:0] v);
      logic [2:0] top;
      if (v[31:28] != 4'd0) begin
         top = 3'd4;
      end else if (v[27:21] != 7'd0) begin
         top = 3'd3;
      end else if (v[20:14] != 7'd0) begin
         top = 3'd2;
      end else if (v[13:7] != 7'd0) begin
         top = 3'd1;
      end else begin
         top = 3'd0;
      end
      return top;
   endfunction

   // one byte of a quantity, continuation bit on every group but the lowest
   function automatic logic [7:0] vlq_byte(input logic [31:0] v, input logic [2:0] g);
      logic [7:0] b;
      case (g)
         3'd0:    b = {1'b0, v[6:0]};
         3'd1:    b = {1'b1, v[13:7]};
         3'd2:    b = {1'b1, v[20:14]};
         3'd3:    b = {1'b1, v[27:21]};
         default: b = {1'b1, 3'b000, v[31:28]};
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== design/mte_req_if.sv =====
// request channel interface carrying track events
`timescale 1ns / 1ps
`default_nettype none

interface mte_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         opcode;
   logic [31:0]        event_tick;
   logic [3:0]         channel;
   logic [7:0]         first_byte;
   logic [7:0]         second_byte;
   logic [7:0]         third_byte;
   logic [7:0]         fourth_byte;
   logic signed [13:0] bend_value;
   logic [23:0]        tempo_value;
   logic [31:0]        payload_length;

   modport source (
      output valid, opcode, event_tick, channel, first_byte, second_byte,
             third_byte, fourth_byte, bend_value, tempo_value, payload_length,
      input  ready
   );

   modport sink (
      input  valid, opcode, event_tick, channel, first_byte, second_byte,
             third_byte, fourth_byte, bend_value, tempo_value, payload_length,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/mte_rsp_if.sv =====
// response channel interface carrying track body bytes
`timescale 1ns / 1ps
`default_nettype none

interface mte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (
      output valid, out_byte, last_of_run,
      input  ready
   );

   modport sink (
      input  valid, out_byte, last_of_run,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/mte_front.sv =====
// front end: accepts requests, tracks tick state and builds byte commands
`timescale 1ns / 1ps
`default_nettype none

module mte_front
   import mte_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mte_req_if.sink    req_chan,
   input  wire logic  q_ready,
   output logic       q_push,
   output mte_cmd_type q_cmd
);

   logic [31:0]    prev_tick_ff;
   logic [31:0]    prev_tick_in;
   logic           eot_ff;
   logic           eot_in;
   logic           accept;
   mte_opcode_type op;
   logic [13:0]    bend_raw;

   assign req_chan.ready = q_ready;
   assign accept         = req_chan.valid && q_ready;
   assign op             = mte_opcode_type'(req_chan.opcode);
   // adding 8192 to a 14-bit value flips its top bit
   assign bend_raw       = {~req_chan.bend_value[13], req_chan.bend_value[12:0]};

   always_comb begin
      q_cmd           = '0;
      q_cmd.has_delta = 1'b1;
      q_cmd.delta     = req_chan.event_tick - prev_tick_ff;
      q_cmd.plen      = req_chan.payload_length;
      q_push          = accept;
      prev_tick_in    = prev_tick_ff;
      eot_in          = eot_ff;

      unique case (op)
         OP_NOTE_OFF, OP_NOTE_ON, OP_POLY_PRESS, OP_CTRL: begin
            q_cmd.msg[0]  = {1'b1, req_chan.opcode[2:0], req_chan.channel};
            q_cmd.msg[1]  = req_chan.first_byte;
            q_cmd.msg[2]  = req_chan.second_byte;
            q_cmd.msg_len = 3'd3;
         end
         OP_PROGRAM, OP_CHAN_PRESS: begin
            q_cmd.msg[0]  = {1'b1, req_chan.opcode[2:0], req_chan.channel};
            q_cmd.msg[1]  = req_chan.first_byte;
            q_cmd.msg_len = 3'd2;
         end
         OP_BEND: begin
            q_cmd.msg[0]  = {STATUS_BEND, req_chan.channel};
            q_cmd.msg[1]  = {1'b0, bend_raw[6:0]};
            q_cmd.msg[2]  = {1'b0, bend_raw[13:7]};
            q_cmd.msg_len = 3'd3;
         end
         OP_TEMPO: begin
            q_cmd.msg[0]  = META_PREFIX;
            q_cmd.msg[1]  = META_TEMPO;
            q_cmd.msg[2]  = LEN_TEMPO;
            q_cmd.msg[3]  = req_chan.tempo_value[23:16];
            q_cmd.msg[4]  = req_chan.tempo_value[15:8];
            q_cmd.msg[5]  = req_chan.tempo_value[7:0];
            q_cmd.msg_len = 3'd6;
         end
         OP_TIMESIG: begin
            q_cmd.msg[0]  = META_PREFIX;
            q_cmd.msg[1]  = META_TIMESIG;
            q_cmd.msg[2]  = LEN_TIMESIG;
            q_cmd.msg[3]  = req_chan.first_byte;
            q_cmd.msg[4]  = req_chan.second_byte;
            q_cmd.msg[5]  = req_chan.third_byte;
            q_cmd.msg[6]  = req_chan.fourth_byte;
            q_cmd.msg_len = 3'd7;
         end
         OP_NAME: begin
            q_cmd.msg[0]   = META_PREFIX;
            q_cmd.msg[1]   = META_NAME;
            q_cmd.msg_len  = 3'd2;
            q_cmd.has_plen = 1'b1;
         end
         OP_EOT: begin
            q_cmd.msg[0]  = META_PREFIX;
            q_cmd.msg[1]  = META_EOT;
            q_cmd.msg[2]  = LEN_ZERO;
            q_cmd.msg_len = 3'd3;
         end
         OP_SYSEX: begin
            q_cmd.msg[0]   = SYSEX_START;
            q_cmd.msg_len  = 3'd1;
            q_cmd.has_plen = 1'b1;
         end
         OP_TEXT, OP_UNK_META: begin
            q_cmd.msg[0]   = META_PREFIX;
            q_cmd.msg[1]   = req_chan.first_byte;
            q_cmd.msg_len  = 3'd2;
            q_cmd.has_plen = 1'b1;
         end
         OP_PAYLOAD: begin
            q_cmd.has_delta = 1'b0;
            q_cmd.msg[0]    = req_chan.first_byte;
            q_cmd.msg_len   = 3'd1;
         end
         OP_CLOSE: begin
            q_cmd.has_delta = 1'b0;
            q_cmd.msg[0]    = LEN_ZERO;
            q_cmd.msg[1]    = META_PREFIX;
            q_cmd.msg[2]    = META_EOT;
            q_cmd.msg[3]    = LEN_ZERO;
            q_cmd.msg_len   = 3'd4;
            q_push          = accept && !eot_ff;
         end
         default: begin
            q_cmd = '0;
         end
      endcase

      if (accept) begin
         if (op == OP_CLOSE) begin
            prev_tick_in = '0;
            eot_in       = 1'b0;
         end else if (op != OP_PAYLOAD) begin
            prev_tick_in = req_chan.event_tick;
            eot_in       = (op == OP_EOT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_tick_ff <= '0;
         eot_ff       <= 1'b0;
      end else begin
         prev_tick_ff <= prev_tick_in;
         eot_ff       <= eot_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mte_cmd_queue.sv =====
// short command queue between front end and serializer
`timescale 1ns / 1ps
`default_nettype none

module mte_cmd_queue
   import mte_pkg::*;
#(
   parameter int DEPTH = MTE_QUEUE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire mte_cmd_type push_cmd,
   output logic        push_ready,
   input  wire logic   pop,
   output logic        pop_valid,
   output mte_cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mte_cmd_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> !push)
      else $error("push into full queue");

endmodule

`default_nettype wire

// ===== design/mte_back.sv =====
// serializer: walks delta, message and length bytes into the response register
`timescale 1ns / 1ps
`default_nettype none

module mte_back
   import mte_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   q_valid,
   input  wire mte_cmd_type q_cmd,
   output logic        q_pop,
   mte_rsp_if.source   rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DELTA,
      ST_MSG,
      ST_PLEN
   } state_type;

   state_type   state_ff;
   state_type   state_in;
   logic [2:0]  idx_ff;
   logic [2:0]  idx_in;
   mte_cmd_type cmd_ff;
   mte_cmd_type cmd_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [7:0]  out_byte_ff;
   logic [7:0]  out_byte_in;
   logic        out_last_ff;
   logic        out_last_in;
   logic        advance;
   logic        cur_last;
   logic [7:0]  cur_byte;
   logic        load;

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.last_of_run = out_last_ff;

   assign advance = (state_ff != ST_IDLE) && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      cur_byte = 8'd0;
      cur_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cur_byte = 8'd0;
         end
         ST_DELTA: begin
            cur_byte = vlq_byte(cmd_ff.delta, idx_ff);
         end
         ST_MSG: begin
            cur_byte = cmd_ff.msg[idx_ff];
            cur_last = (idx_ff == cmd_ff.msg_len - 3'd1) && !cmd_ff.has_plen;
         end
         ST_PLEN: begin
            cur_byte = vlq_byte(cmd_ff.plen, idx_ff);
            cur_last = (idx_ff == 3'd0);
         end
         default: begin
            cur_byte = 8'd0;
         end
      endcase
   end

   assign load  = q_valid && ((state_ff == ST_IDLE) || (advance && cur_last));
   assign q_pop = load;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = cur_last;
         unique case (state_ff)
            ST_DELTA: begin
               if (idx_ff == 3'd0) begin
                  state_in = ST_MSG;
               end else begin
                  idx_in = idx_ff - 3'd1;
               end
            end
            ST_MSG: begin
               if (idx_ff == cmd_ff.msg_len - 3'd1) begin
                  if (cmd_ff.has_plen) begin
                     state_in = ST_PLEN;
                     idx_in   = vlq_top(cmd_ff.plen);
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
            ST_PLEN: begin
               if (idx_ff == 3'd0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 3'd1;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      if (load) begin
         cmd_in   = q_cmd;
         state_in = q_cmd.has_delta ? ST_DELTA : ST_MSG;
         idx_in   = q_cmd.has_delta ? vlq_top(q_cmd.delta) : 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff      <= idx_in;
      cmd_ff      <= cmd_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   a_msg_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MSG) |-> (idx_ff < cmd_ff.msg_len))
      else $error("message index beyond length");

   a_delta_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELTA) |-> cmd_ff.has_delta)
      else $error("delta phase without delta");

   a_plen_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLEN) |-> cmd_ff.has_plen)
      else $error("length phase without length");

endmodule

`default_nettype wire

// ===== design/midi_track_event_encoder_top.sv =====
// top level of the midi track event encoder
//
//  channel   dir  handshake          payload
//  req_chan  in   valid / ready      opcode, tick, channel, data bytes, bend, tempo, length
//  rsp_chan  out  valid / ready      out_byte, last_of_run
//
// one request accepted per cycle while the command queue has room
// the serializer emits one byte per cycle while rsp_chan is ready; a request yields
// 1 byte for payload, 4 or none for close, up to 12 for the longest events
// synchronous reset clears tick state, end marker flag, queue and output register
// response stalls fill the output register and then the queue, and drop req_chan.ready
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_encoder_top
   import mte_pkg::*;
#(
   parameter int QUEUE_DEPTH = MTE_QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   mte_req_if.sink   req_chan,
   mte_rsp_if.source rsp_chan
);

   logic        q_push;
   logic        q_ready;
   logic        q_pop;
   logic        q_valid;
   mte_cmd_type push_cmd;
   mte_cmd_type pop_cmd;

   mte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   mte_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (pop_cmd)
   );

   mte_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (pop_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
